@@ hw/rtl/btpf_pkg.sv @@
`timescale 1ns / 1ps
package btpf_pkg;

  localparam int unsigned VramBytes = 8192;
  localparam int unsigned VramAddrW = 13;
  localparam int unsigned PixW      = 8;
  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned CfgDataW  = 32;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdRender = 1'b1;

  localparam logic [2:0] RegLcdControl = 3'd0;
  localparam logic [2:0] RegScrollY    = 3'd1;
  localparam logic [2:0] RegScrollX    = 3'd2;
  localparam logic [2:0] RegWindowY    = 3'd3;
  localparam logic [2:0] RegWindowX    = 3'd4;
  localparam logic [2:0] RegBgPalette  = 3'd5;

  localparam logic [7:0] LcdControlRst = 8'd145;
  localparam logic [7:0] BgPaletteRst  = 8'd252;

  // lcd_control bit positions
  localparam int unsigned LcdcBgMap    = 3;
  localparam int unsigned LcdcTileMode = 4;
  localparam int unsigned LcdcWinEn    = 5;
  localparam int unsigned LcdcWinMap   = 6;

  localparam logic [7:0] LastLine   = 8'd143;
  localparam logic [7:0] LastColumn = 8'd159;
  localparam logic [7:0] WinXOffset = 8'd7;

  // tile maps sit at 0x1800 / 0x1C00: top two address bits are 11, bit 10 picks the map
  localparam logic [1:0] MapBaseHi = 2'b11;
  // signed tile data centers on 0x1000: block index of 0x0800 in 16-byte units
  localparam logic [8:0] TileSignedBlk = 9'h080;
  localparam logic [7:0] TileSignFlip  = 8'h80;

  localparam logic [1:0] ShadeWhite = 2'd0;
  localparam logic [1:0] ShadeLight = 2'd1;
  localparam logic [1:0] ShadeDark  = 2'd2;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
  } cfg_t;

  function automatic logic [7:0] grey_of(input logic [1:0] shade);
    logic [7:0] g;
    case (shade)
      ShadeWhite: g = 8'hFF;
      ShadeLight: g = 8'hCC;
      ShadeDark:  g = 8'h77;
      default:    g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/btpf_in_if.sv @@
`timescale 1ns / 1ps
interface btpf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [btpf_pkg::VramAddrW-1:0]     vram_addr;
  logic [7:0]                         vram_data;
  logic [btpf_pkg::PixW-1:0]          scan_line;
  logic [btpf_pkg::PixW-1:0]          column;

  modport source (output valid, cmd, vram_addr, vram_data, scan_line, column, input ready);
  modport sink (input valid, cmd, vram_addr, vram_data, scan_line, column, output ready);
endinterface

@@ hw/rtl/btpf_out_if.sv @@
`timescale 1ns / 1ps
interface btpf_out_if;
  logic                      valid;
  logic                      ready;
  logic [btpf_pkg::PixW-1:0] out_column;
  logic [btpf_pkg::PixW-1:0] out_line;
  logic [1:0]                shade;
  logic [7:0]                grey_level;

  modport source (output valid, out_column, out_line, shade, grey_level, input ready);
  modport sink (input valid, out_column, out_line, shade, grey_level, output ready);
endinterface

@@ hw/rtl/btpf_ram.sv @@
`timescale 1ns / 1ps
module btpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read and write of the same entry returns the old byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/btpf_cfg.sv @@
`timescale 1ns / 1ps
module btpf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [btpf_pkg::CfgAddrW-1:0]   paddr,
  input  logic [btpf_pkg::CfgDataW-1:0]   pwdata,
  output logic [btpf_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output btpf_pkg::cfg_t                  cfg_o
);
  import btpf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] wbyte;
  logic [7:0] rbyte;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign wbyte   = pwdata[7:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegLcdControl: cfg_d.lcd_control = wbyte;
        RegScrollY:    cfg_d.scroll_y    = wbyte;
        RegScrollX:    cfg_d.scroll_x    = wbyte;
        RegWindowY:    cfg_d.window_y    = wbyte;
        RegWindowX:    cfg_d.window_x    = wbyte;
        RegBgPalette:  cfg_d.bg_palette  = wbyte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_control <= LcdControlRst;
      cfg_q.scroll_y    <= '0;
      cfg_q.scroll_x    <= '0;
      cfg_q.window_y    <= '0;
      cfg_q.window_x    <= '0;
      cfg_q.bg_palette  <= BgPaletteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegLcdControl: rbyte = cfg_q.lcd_control;
      RegScrollY:    rbyte = cfg_q.scroll_y;
      RegScrollX:    rbyte = cfg_q.scroll_x;
      RegWindowY:    rbyte = cfg_q.window_y;
      RegWindowX:    rbyte = cfg_q.window_x;
      RegBgPalette:  rbyte = cfg_q.bg_palette;
      default:       rbyte = '0;
    endcase
  end

  assign prdata = {{(CfgDataW-8){1'b0}}, rbyte};
  assign cfg_o  = cfg_q;

endmodule

@@ hw/rtl/btpf_fetch.sv @@
`timescale 1ns / 1ps
module btpf_fetch #(
  parameter int unsigned VRAM_BYTES = btpf_pkg::VramBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  btpf_pkg::cfg_t cfg_i,
  btpf_in_if.sink        in_i,
  btpf_out_if.source     out_o
);
  import btpf_pkg::*;

  localparam int unsigned BankDepth = VRAM_BYTES / 2;
  localparam int unsigned BankAw    = $clog2(BankDepth);

  // stage 0: map address from the accepted word
  logic                 acc, acc_wr, acc_px, in_rdy;
  logic [7:0]           win_edge, ypos, xpos;
  logic                 use_win, map_sel;
  logic [VramAddrW-1:0] map_addr;

  // stage 1: map byte returned, tile row read issued
  logic        s1_vld_q, s1_vld_d, s1_adv;
  logic [7:0]  s1_line_q, s1_col_q;
  logic [2:0]  s1_row_q, s1_xbit_q;
  logic        s1_odd_q;
  logic [7:0]  tile_num;
  logic [8:0]  tile_blk;
  logic [BankAw-1:0] tile_word;

  // stage 2: bit-plane bytes returned
  logic        s2_vld_q, s2_vld_d, s2_go, s2_load;
  logic [7:0]  s2_line_q, s2_col_q;
  logic [2:0]  s2_xbit_q, s2_bit;
  logic [1:0]  color_id, shade;

  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_col_q, out_line_q, out_grey_q;
  logic [1:0]  out_shade_q;

  // banks split on address bit 0: even holds low plane, odd high plane
  logic              we_even, we_odd, rd_en;
  logic [BankAw-1:0] rd_word;
  logic [7:0]        rd_even, rd_odd;

  assign s2_go   = !out_vld_q || out_o.ready;
  assign in_rdy  = !s1_vld_q && (!s2_vld_q || s2_go);
  assign in_i.ready = in_rdy;

  assign acc    = in_i.valid && in_rdy;
  assign acc_wr = acc && (in_i.cmd == CmdWrite);
  assign acc_px = acc && (in_i.cmd == CmdRender) &&
                  (in_i.scan_line <= LastLine) && (in_i.column <= LastColumn);

  assign win_edge = cfg_i.window_x - WinXOffset;
  assign use_win  = cfg_i.lcd_control[LcdcWinEn] && (in_i.scan_line >= cfg_i.window_y) &&
                    (in_i.column >= win_edge);

  always_comb begin
    if (use_win) begin
      map_sel = cfg_i.lcd_control[LcdcWinMap];
      ypos    = in_i.scan_line - cfg_i.window_y;
      xpos    = in_i.column - win_edge;
    end else begin
      map_sel = cfg_i.lcd_control[LcdcBgMap];
      ypos    = cfg_i.scroll_y + in_i.scan_line;
      xpos    = cfg_i.scroll_x + in_i.column;
    end
  end

  assign map_addr = {MapBaseHi, map_sel, ypos[7:3], xpos[7:3]};

  assign s1_adv   = s1_vld_q && (!s2_vld_q || s2_go);
  assign tile_num = s1_odd_q ? rd_odd : rd_even;
  assign tile_blk = cfg_i.lcd_control[LcdcTileMode] ? {1'b0, tile_num}
                  : TileSignedBlk + {1'b0, tile_num ^ TileSignFlip};
  assign tile_word = {tile_blk, s1_row_q};

  assign rd_en   = acc_px || s1_adv;
  assign rd_word = s1_adv ? tile_word : map_addr[BankAw:1];
  assign we_even = acc_wr && !in_i.vram_addr[0];
  assign we_odd  = acc_wr && in_i.vram_addr[0];

  btpf_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (in_i.vram_addr[BankAw:1]),
    .wdata_i (in_i.vram_data),
    .re_i    (rd_en),
    .raddr_i (rd_word),
    .rdata_o (rd_even)
  );

  btpf_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (in_i.vram_addr[BankAw:1]),
    .wdata_i (in_i.vram_data),
    .re_i    (rd_en),
    .raddr_i (rd_word),
    .rdata_o (rd_odd)
  );

  assign s2_bit   = ~s2_xbit_q;
  assign color_id = {rd_odd[s2_bit], rd_even[s2_bit]};
  assign shade    = 2'(cfg_i.bg_palette >> {color_id, 1'b0});
  assign s2_load  = s2_vld_q && s2_go;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (acc_px) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    s2_vld_d = s2_vld_q;
    if (s1_adv) begin
      s2_vld_d = 1'b1;
    end else if (s2_go) begin
      s2_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s2_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_px) begin
      s1_line_q <= in_i.scan_line;
      s1_col_q  <= in_i.column;
      s1_row_q  <= ypos[2:0];
      s1_xbit_q <= xpos[2:0];
      s1_odd_q  <= map_addr[0];
    end
    if (s1_adv) begin
      s2_line_q <= s1_line_q;
      s2_col_q  <= s1_col_q;
      s2_xbit_q <= s1_xbit_q;
    end
    if (s2_load) begin
      out_col_q   <= s2_col_q;
      out_line_q  <= s2_line_q;
      out_shade_q <= shade;
      out_grey_q  <= grey_of(shade);
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_column = out_col_q;
  assign out_o.out_line   = out_line_q;
  assign out_o.shade      = out_shade_q;
  assign out_o.grey_level = out_grey_q;

  // one read per bank per cycle: map and tile reads never collide
  a_read_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_px && s1_adv)) else $error("map and tile read in the same cycle");

  // a held tile row must not be overwritten while the result waits
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !s2_go) |=> (s2_vld_q && !$past(rd_en)))
    else $error("stage 2 data lost under stall");

  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_px |=> s1_vld_q) else $error("visible pixel did not enter stage 1");

  a_s1_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s2_vld_q) |=> (s2_vld_q && !s1_vld_q))
    else $error("stage 1 did not advance into empty stage 2");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_vld_q) else $error("stage 2 result not registered");

endmodule

@@ hw/rtl/background_tile_pixel_fetch.sv @@
`timescale 1ns / 1ps
// Background/window pixel fetch with 8 KB of video memory.
// Input channel in_i carries one word per item: cmd 0 stores vram_data at
// vram_addr, cmd 1 renders the pixel at (scan_line, column). Output channel
// out_o carries one word per visible rendered pixel (line <= 143,
// column <= 159): column, line, shade and its grey level. Stores and
// invisible pixels give no output word.
// Rendering reads the tile map byte, then both bit-plane bytes of the tile row
// together from even/odd memory banks; the pixel passes stage 1, stage 2 and the
// output register. A rendered pixel holds the read port for its map and tile-row
// reads, so no word is taken while it sits in stage 1; a store does not hold it.
// Registers must be written over the APB port only while the block is idle; the
// block does not enforce this. If the receiver stalls, the output register holds
// its word, one more pixel waits in stage 2, and then in_i.ready drops.
// Reset clears the pipeline and loads the register reset values; video
// memory is not cleared and must be written before it is rendered from.
module background_tile_pixel_fetch #(
  parameter int unsigned VRAM_BYTES = btpf_pkg::VramBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btpf_pkg::CfgAddrW-1:0] paddr,
  input  logic [btpf_pkg::CfgDataW-1:0] pwdata,
  output logic [btpf_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  btpf_in_if.sink                       in_i,
  btpf_out_if.source                    out_o
);
  import btpf_pkg::*;

  cfg_t cfg;

  btpf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  btpf_fetch #(.VRAM_BYTES(VRAM_BYTES)) u_fetch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
